>>> rtl/emrl_pkg.sv
// Shared types, codes and fixed-point helpers for the explicit MPC region lookup core.
// No dependencies; emrl_dp, emrl_ctrl and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none
package emrl_pkg;

    localparam int NumRegions = 64;
    localparam int NumRows    = 256;
    localparam int NumOutputs = 4;
    localparam int HsDepth    = NumRows * 4;
    localparam int OffDepth   = NumRegions + 1;
    localparam int LinDepth   = NumRegions * 4;
    localparam int QuadDepth  = (NumRegions - 1) * 9;
    localparam int GainDepth  = NumRegions * NumOutputs * 4;

    localparam logic [2:0] MEM_HS   = 3'd0;
    localparam logic [2:0] MEM_OFF  = 3'd1;
    localparam logic [2:0] MEM_LIN  = 3'd2;
    localparam logic [2:0] MEM_QUAD = 3'd3;
    localparam logic [2:0] MEM_GAIN = 3'd4;
    localparam logic [2:0] ACT_EVAL = 3'd5;
    localparam logic [2:0] PH_QT    = 3'd6;

    localparam logic [2:0] B_X0  = 3'd0;
    localparam logic [2:0] B_X1  = 3'd1;
    localparam logic [2:0] B_X2  = 3'd2;
    localparam logic [2:0] B_NEG = 3'd3;
    localparam logic [2:0] B_POS = 3'd4;

    localparam logic [1:0] CFG_REGIONS = 2'd0;
    localparam logic [1:0] CFG_OUTPUTS = 2'd1;
    localparam logic [1:0] CFG_TOL     = 2'd2;

    typedef struct packed {
        logic        ld;
        logic        eval_start;
        logic [2:0]  mem;
        logic [9:0]  addr;
        logic        mul_en;
        logic        a_q16;
        logic [2:0]  b_sel;
        logic        acc_clr_a;
        logic        acc_clr_q;
        logic        add_en;
        logic        add_q;
        logic        best_upd;
        logic [5:0]  region;
        logic        ctrl_wr;
        logic [1:0]  ctrl_idx;
        logic        out_load;
        logic [15:0] tol;
    } t_cmd;

    typedef struct packed {
        logic [8:0] off_data;
        logic       feas_fail;
        logic       found;
        logic [5:0] best;
        logic       out_busy;
    } t_stat;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_add = s[63:0];
        end
    endfunction

    function automatic logic signed [31:0] to_q16(input logic signed [63:0] v);
        logic signed [47:0] t;
        t = v[63:16];
        if (t > $signed(48'sh0000_7FFF_FFFF)) begin
            to_q16 = 32'sh7FFF_FFFF;
        end else if (t < $signed(48'shFFFF_8000_0000)) begin
            to_q16 = 32'sh8000_0000;
        end else begin
            to_q16 = t[31:0];
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/emrl_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module emrl_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire  [AddrW-1:0] i_addr,
    input  wire  [Width-1:0] i_wdata,
    output logic [Width-1:0] o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> rtl/emrl_dp.sv
// Datapath: table memories, one multiplier, saturating accumulators, best-region and result registers.
// Depends on emrl_pkg and emrl_ram.
`timescale 1ns / 1ps
`default_nettype none
module emrl_dp import emrl_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_cmd         i_cmd,
    output t_stat        o_stat,
    input  wire   [9:0]  i_index,
    input  wire   [31:0] i_value,
    input  wire   [31:0] i_x0,
    input  wire   [31:0] i_x1,
    input  wire   [31:0] i_x2,
    input  wire          i_out_ready,
    output logic         o_out_valid,
    output logic  [5:0]  o_region,
    output logic         o_found,
    output logic  [31:0] o_ctrl0,
    output logic  [31:0] o_ctrl1,
    output logic  [31:0] o_ctrl2,
    output logic  [31:0] o_ctrl3
);
    logic [9:0]  addr;
    logic [31:0] hs_q, lin_q, quad_q, gain_q;
    logic [8:0]  off_q;
    logic        we_hs, we_off, we_lin, we_quad, we_gain;
    logic signed [31:0] r_x [3];
    logic signed [31:0] r_ctrl [NumOutputs];
    logic signed [63:0] r_prod, r_acca, r_accq, r_best_score;
    logic        r_found, r_ov;
    logic [5:0]  r_best;
    logic signed [31:0] op_a, op_b, ram_sel;

    assign addr    = i_cmd.ld ? i_index : i_cmd.addr;
    assign we_hs   = i_cmd.ld && i_cmd.mem == MEM_HS   && {22'd0, i_index} < HsDepth;
    assign we_off  = i_cmd.ld && i_cmd.mem == MEM_OFF  && {22'd0, i_index} < OffDepth;
    assign we_lin  = i_cmd.ld && i_cmd.mem == MEM_LIN  && {22'd0, i_index} < LinDepth;
    assign we_quad = i_cmd.ld && i_cmd.mem == MEM_QUAD && {22'd0, i_index} < QuadDepth;
    assign we_gain = i_cmd.ld && i_cmd.mem == MEM_GAIN && {22'd0, i_index} < GainDepth;

    emrl_ram #(.Width(32), .Depth(HsDepth)) u_hs (
        .i_clk, .i_we(we_hs), .i_addr(addr[$clog2(HsDepth)-1:0]),
        .i_wdata(i_value), .o_rdata(hs_q));
    emrl_ram #(.Width(9), .Depth(OffDepth)) u_off (
        .i_clk, .i_we(we_off), .i_addr(addr[$clog2(OffDepth)-1:0]),
        .i_wdata(i_value[8:0]), .o_rdata(off_q));
    emrl_ram #(.Width(32), .Depth(LinDepth)) u_lin (
        .i_clk, .i_we(we_lin), .i_addr(addr[$clog2(LinDepth)-1:0]),
        .i_wdata(i_value), .o_rdata(lin_q));
    emrl_ram #(.Width(32), .Depth(QuadDepth)) u_quad (
        .i_clk, .i_we(we_quad), .i_addr(addr[$clog2(QuadDepth)-1:0]),
        .i_wdata(i_value), .o_rdata(quad_q));
    emrl_ram #(.Width(32), .Depth(GainDepth)) u_gain (
        .i_clk, .i_we(we_gain), .i_addr(addr[$clog2(GainDepth)-1:0]),
        .i_wdata(i_value), .o_rdata(gain_q));

    always_comb begin
        case (i_cmd.mem)
            MEM_HS:   ram_sel = hs_q;
            MEM_LIN:  ram_sel = lin_q;
            MEM_QUAD: ram_sel = quad_q;
            default:  ram_sel = gain_q;
        endcase
        op_a = i_cmd.a_q16 ? to_q16(r_accq) : ram_sel;
        case (i_cmd.b_sel)
            B_X0:    op_b = r_x[0];
            B_X1:    op_b = r_x[1];
            B_X2:    op_b = r_x[2];
            B_NEG:   op_b = -32'sd65536;
            default: op_b = 32'sd65536;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_start) begin
            r_x[0] <= i_x0;
            r_x[1] <= i_x1;
            r_x[2] <= i_x2;
            r_best <= 6'd0;
            r_best_score <= 64'sd0;
            for (int j = 0; j < NumOutputs; j++) begin
                r_ctrl[j] <= 32'sd0;
            end
        end
        if (i_cmd.mul_en) begin
            r_prod <= op_a * op_b;
        end
        if (i_cmd.acc_clr_a) begin
            r_acca <= 64'sd0;
        end else if (i_cmd.add_en && !i_cmd.add_q) begin
            r_acca <= sat_add(r_acca, r_prod);
        end
        if (i_cmd.acc_clr_q) begin
            r_accq <= 64'sd0;
        end else if (i_cmd.add_en && i_cmd.add_q) begin
            r_accq <= sat_add(r_accq, r_prod);
        end
        if (i_cmd.best_upd && (!r_found || r_acca < r_best_score)) begin
            r_best <= i_cmd.region;
            r_best_score <= r_acca;
        end
        if (i_cmd.ctrl_wr) begin
            r_ctrl[i_cmd.ctrl_idx] <= to_q16(r_acca);
        end
        if (i_cmd.out_load) begin
            o_region <= r_best;
            o_found  <= r_found;
            o_ctrl0  <= r_ctrl[0];
            o_ctrl1  <= r_ctrl[1];
            o_ctrl2  <= r_ctrl[2];
            o_ctrl3  <= r_ctrl[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.eval_start) begin
                r_found <= 1'b0;
            end else if (i_cmd.best_upd) begin
                r_found <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_stat.off_data  = off_q;
    assign o_stat.feas_fail = r_acca > $signed({32'd0, i_cmd.tol, 16'd0});
    assign o_stat.found     = r_found;
    assign o_stat.best      = r_best;
    assign o_stat.out_busy  = r_ov && !i_out_ready;
endmodule
`default_nettype wire

>>> rtl/emrl_ctrl.sv
// Controller: configuration registers and the sequencer that walks regions, rows and gains.
// Depends on emrl_pkg; drives emrl_dp through t_cmd and reads t_stat.
`timescale 1ns / 1ps
`default_nettype none
module emrl_ctrl import emrl_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [2:0]  i_action,
    input  wire         i_cfg_valid,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    output t_cmd        o_cmd,
    input  t_stat       i_stat
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_OFF_A = 4'd1;
    localparam logic [3:0] S_OFF_B = 4'd2;
    localparam logic [3:0] S_OFF_C = 4'd3;
    localparam logic [3:0] S_ROW   = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_CHK   = 4'd8;
    localparam logic [3:0] S_SCORE = 4'd9;
    localparam logic [3:0] S_NEXT  = 4'd10;
    localparam logic [3:0] S_GOUT  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0]  r_state, n_state;
    logic [2:0]  r_phase, n_phase;
    logic [6:0]  r_i, n_i;
    logic [1:0]  r_j, n_j, r_k, n_k, r_rq, n_rq;
    logic signed [10:0] r_row, n_row, r_end, n_end;
    logic [6:0]  r_nr, n_nr, r_cfg_regions;
    logic [2:0]  r_nz, n_nz, r_cfg_outputs;
    logic [15:0] r_cfg_tol;
    logic        accept;
    logic [9:0]  im1, quad_addr;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept = i_in_valid && o_in_ready;
    assign im1 = {3'd0, r_i} - 10'd1;
    assign quad_addr = {im1[6:0], 3'd0} + im1 + {8'd0, r_rq} + {7'd0, r_rq, 1'b0} + {8'd0, r_k};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_regions <= 7'd1;
            r_cfg_outputs <= 3'd1;
            r_cfg_tol     <= 16'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REGIONS: r_cfg_regions <= i_cfg_data[6:0];
                CFG_OUTPUTS: r_cfg_outputs <= i_cfg_data[2:0];
                CFG_TOL:     r_cfg_tol     <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        n_rq = r_rq;
        n_row = r_row;
        n_end = r_end;
        n_nr = r_nr;
        n_nz = r_nz;
        o_cmd = '0;
        o_cmd.tol = r_cfg_tol;
        o_cmd.region = r_i[5:0];
        o_cmd.ctrl_idx = r_j;
        o_cmd.mem = r_phase;
        case (r_phase)
            MEM_HS:   o_cmd.addr = {r_row[7:0], r_k};
            MEM_LIN:  o_cmd.addr = {2'd0, r_i[5:0], r_k};
            MEM_QUAD: o_cmd.addr = quad_addr;
            default:  o_cmd.addr = {i_stat.best, r_j, r_k};
        endcase
        if (r_phase == PH_QT) begin
            o_cmd.b_sel = {1'b0, r_rq};
        end else if (r_k != 2'd3) begin
            o_cmd.b_sel = {1'b0, r_k};
        end else begin
            o_cmd.b_sel = (r_phase == MEM_HS) ? B_NEG : B_POS;
        end
        o_cmd.a_q16 = (r_phase == PH_QT);

        unique case (r_state)
            S_IDLE: begin
                o_cmd.mem = i_action;
                if (accept && i_action < ACT_EVAL) begin
                    o_cmd.ld = 1'b1;
                end else if (accept && i_action == ACT_EVAL) begin
                    o_cmd.eval_start = 1'b1;
                    n_i = 7'd0;
                    n_nr = (r_cfg_regions > 7'd64) ? 7'd64 : r_cfg_regions;
                    n_nz = (r_cfg_outputs > 3'd4) ? 3'd4 : r_cfg_outputs;
                    n_state = (r_cfg_regions == 7'd0) ? S_DONE : S_OFF_A;
                end
            end
            S_OFF_A: begin
                o_cmd.mem = MEM_OFF;
                o_cmd.addr = {3'd0, r_i};
                n_state = S_OFF_B;
            end
            S_OFF_B: begin
                o_cmd.mem = MEM_OFF;
                o_cmd.addr = {3'd0, r_i + 7'd1};
                n_row = $signed({2'd0, i_stat.off_data}) - 11'sd1;
                n_state = S_OFF_C;
            end
            S_OFF_C: begin
                n_end = $signed({2'd0, i_stat.off_data}) - 11'sd1;
                n_state = S_ROW;
            end
            S_ROW: begin
                o_cmd.acc_clr_a = 1'b1;
                n_k = 2'd0;
                if (r_row >= r_end) begin
                    n_phase = MEM_LIN;
                    n_state = S_RD;
                end else if (r_row[10] || r_row[9:8] != 2'd0) begin
                    n_row = r_row + 11'sd1;
                end else begin
                    n_phase = MEM_HS;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.add_en = 1'b1;
                o_cmd.add_q = (r_phase == MEM_QUAD);
                n_state = S_RD;
                if (r_phase == PH_QT) begin
                    if (r_rq == 2'd2) begin
                        n_state = S_SCORE;
                    end else begin
                        n_rq = r_rq + 2'd1;
                        n_k = 2'd0;
                        n_phase = MEM_QUAD;
                    end
                end else if (r_phase == MEM_QUAD && r_k == 2'd2) begin
                    n_phase = PH_QT;
                    n_state = S_MUL;
                end else if (r_phase != MEM_QUAD && r_k == 2'd3) begin
                    n_k = 2'd0;
                    unique case (r_phase)
                        MEM_HS:  n_state = S_CHK;
                        MEM_LIN: begin
                            if (r_i == 7'd0) begin
                                n_state = S_SCORE;
                            end else begin
                                n_rq = 2'd0;
                                n_phase = MEM_QUAD;
                            end
                        end
                        default: n_state = S_GOUT;
                    endcase
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_CHK: begin
                if (i_stat.feas_fail) begin
                    n_state = S_NEXT;
                end else begin
                    n_row = r_row + 11'sd1;
                    n_state = S_ROW;
                end
            end
            S_SCORE: begin
                o_cmd.best_upd = 1'b1;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                o_cmd.acc_clr_a = 1'b1;
                o_cmd.acc_clr_q = 1'b1;
                n_j = 2'd0;
                n_k = 2'd0;
                if (r_i + 7'd1 < r_nr) begin
                    n_i = r_i + 7'd1;
                    n_state = S_OFF_A;
                end else if (i_stat.found && r_nz != 3'd0) begin
                    n_phase = MEM_GAIN;
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_GOUT: begin
                o_cmd.ctrl_wr = 1'b1;
                o_cmd.acc_clr_a = 1'b1;
                n_k = 2'd0;
                if ({1'b0, r_j} + 3'd1 < r_nz) begin
                    n_j = r_j + 2'd1;
                    n_state = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_ACC && r_phase == MEM_LIN && r_k == 2'd3 && r_i != 7'd0) begin
            o_cmd.acc_clr_q = 1'b1;
        end
        if (r_state == S_ACC && r_phase == PH_QT && r_rq != 2'd2) begin
            o_cmd.acc_clr_q = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= MEM_HS;
            r_i <= 7'd0;
            r_j <= 2'd0;
            r_k <= 2'd0;
            r_rq <= 2'd0;
            r_nr <= 7'd1;
            r_nz <= 3'd1;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_i <= n_i;
            r_j <= n_j;
            r_k <= n_k;
            r_rq <= n_rq;
            r_nr <= n_nr;
            r_nz <= n_nz;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_end <= n_end;
    end

    a_region_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OFF_A) |-> (r_i < r_nr))
        else $error("region walk passed the region count");
    a_gain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GOUT) |-> ({1'b0, r_j} < r_nz && i_stat.found))
        else $error("gain row written beyond output count or without a region");
    a_quad_elems: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD && r_phase == MEM_QUAD) |-> (r_k != 2'd3 && r_i != 7'd0))
        else $error("quadratic block read out of range");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld |-> (r_state == S_IDLE && !o_cmd.eval_start))
        else $error("table write outside idle");
endmodule
`default_nettype wire

>>> rtl/explicit_mpc_region_lookup_core.sv
// Top level of the explicit MPC region lookup core: stream ports and configuration port.
// Depends on emrl_pkg, emrl_ctrl and emrl_dp.
//
// Channel   Direction  Beat contents
// s_axis    in         tuser: action[2:0]; tdata: table_index, table_value, state0..2
// m_axis    out        tuser: found; tdata: region_index, control0..3
// cfg       in         index 0 region count, 1 output count, 2 tolerance
//
// A load beat is written to its table as it is accepted. An evaluate beat walks each region:
// it fetches the region's offsets, tests each half-space row and skips rows out of range,
// scores a feasible region, adding the quadratic term after the first region, and then
// computes each control output. All of this is serialised on the single multiplier and tables.
// Reset is synchronous and active low; the tables are not cleared.
// A result waiting on m_axis holds the next evaluate in its last cycle, and no beat is
// accepted until the result drains; loads ahead of that evaluate are still accepted.
`timescale 1ns / 1ps
`default_nettype none
module explicit_mpc_region_lookup_core import emrl_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           s_axis_tvalid,
    output logic          s_axis_tready,
    input  wire  [143:0]  s_axis_tdata,  // table_index, table_value, state0, state1, state2
    input  wire  [2:0]    s_axis_tuser,  // action
    output logic          m_axis_tvalid,
    input  wire           m_axis_tready,
    output logic [135:0]  m_axis_tdata,  // region_index, control0, control1, control2, control3
    output logic          m_axis_tuser,  // found
    input  wire           i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire  [1:0]    i_cfg_index,
    input  wire  [15:0]   i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;
    logic [5:0]  region;
    logic [31:0] c0, c1, c2, c3;

    assign o_cfg_ready = 1'b1;

    emrl_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_action(s_axis_tuser),
        .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .o_cmd(cmd), .i_stat(stat)
    );

    emrl_dp u_dp (
        .i_clk, .i_rst_n,
        .i_cmd(cmd), .o_stat(stat),
        .i_index(s_axis_tdata[9:0]), .i_value(s_axis_tdata[41:10]),
        .i_x0(s_axis_tdata[73:42]), .i_x1(s_axis_tdata[105:74]),
        .i_x2(s_axis_tdata[137:106]),
        .i_out_ready(m_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_region(region), .o_found(m_axis_tuser),
        .o_ctrl0(c0), .o_ctrl1(c1), .o_ctrl2(c2), .o_ctrl3(c3)
    );

    assign m_axis_tdata = {2'd0, c3, c2, c1, c0, region};
endmodule
`default_nettype wire
